FILE: rtl/core/les_pkg.sv
// Package for the LOOK elevator scheduler: sizes, input kind codes,
// shared structs and the LOOK ranking function. No dependencies.
package les_pkg;

    localparam int MAX_FLOORS = 32;
    localparam int TIMER_BITS = 17;
    localparam int FLOOR_W    = 6;
    localparam int TICKS_W    = 16;
    localparam int KIND_W     = 2;
    localparam int ADDR_W     = $clog2(MAX_FLOORS);

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HALL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;

    typedef logic [MAX_FLOORS-1:0] map_t;
    typedef logic [FLOOR_W-1:0]    floor_t;
    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    typedef struct packed {
        floor_t              top_floor;
        logic [TICKS_W-1:0]  floor_ticks;
    } cfg_t;

    typedef struct packed {
        floor_t cabin_floor;
        logic   moving;
        logic   going_up;
        floor_t next_floor;
        logic   arrived;
        logic   served;
        logic   rejected;
    } res_t;

    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        map_t  wr_data;
    } mem_req_t;

    // Head by LOOK: nearest ahead in direction, else current floor, else nearest behind.
    function automatic floor_t look_rank(map_t tmap, floor_t cur, logic up);
        map_t   ahead;
        map_t   behind;
        floor_t above;
        floor_t below;
        logic   here;
        addr_t  idx;
        floor_t head;
        idx    = ADDR_W'(cur - FLOOR_W'(1));
        ahead  = tmap & ~((map_t'(1) << cur) - map_t'(1));
        behind = tmap & ((map_t'(1) << idx) - map_t'(1));
        here   = tmap[idx];
        above  = '0;
        below  = '0;
        for (int i = MAX_FLOORS - 1; i >= 0; i--)
        begin
            if (ahead[i])
            begin
                above = FLOOR_W'(i + 1);
            end
        end
        for (int i = 0; i < MAX_FLOORS; i++)
        begin
            if (behind[i])
            begin
                below = FLOOR_W'(i + 1);
            end
        end
        if (up)
        begin
            head = (above != '0) ? above : (here ? cur : below);
        end
        else
        begin
            head = (below != '0) ? below : (here ? cur : above);
        end
        return head;
    endfunction

endpackage

FILE: rtl/core/les_row_mem.sv
// Pending-destination row memory: one write and one registered read per cycle,
// per-row valid bits for reset and a bypass of the latest write. Uses les_pkg.
module les_row_mem
(
    input  logic              clk,
    input  logic              rst_n,
    input  les_pkg::mem_req_t req,
    output les_pkg::map_t     row
);

    les_pkg::map_t                   rows_reg [les_pkg::MAX_FLOORS];
    les_pkg::map_t                   rdata_reg;
    logic [les_pkg::MAX_FLOORS-1:0]  valid_reg;
    logic                            rd_valid_reg;
    les_pkg::addr_t                  rd_addr_reg;
    logic                            byp_valid_reg;
    les_pkg::addr_t                  byp_addr_reg;
    les_pkg::map_t                   byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            rows_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= rows_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_addr_reg   <= '0;
            byp_valid_reg <= 1'b0;
            byp_addr_reg  <= '0;
            byp_data_reg  <= '0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
                byp_valid_reg          <= 1'b1;
                byp_addr_reg           <= req.wr_addr;
                byp_data_reg           <= req.wr_data;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
                rd_addr_reg  <= req.rd_addr;
            end
        end
    end

    assign row = (byp_valid_reg && (byp_addr_reg == rd_addr_reg)) ? byp_data_reg :
                 (rd_valid_reg ? rdata_reg : '0);

endmodule

FILE: rtl/core/les_ctrl.sv
// Scheduler control: cabin state, target map, LOOK ranking and the item
// path around the pending-row memory. Uses les_pkg.
module les_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  les_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [les_pkg::KIND_W-1:0]    kind,
    input  les_pkg::floor_t               call_floor,
    input  les_pkg::floor_t               dest_floor,
    output logic                          res_valid,
    input  logic                          res_ready,
    output les_pkg::res_t                 res,
    output les_pkg::mem_req_t             mem_req,
    input  les_pkg::map_t                 row
);

    typedef struct packed {
        logic           serve;
        logic           wr_hall;
        les_pkg::addr_t addr;
        les_pkg::map_t  set_bits;
        les_pkg::res_t  res;
    } stage_t;

    localparam les_pkg::timer_t TIMER_MAX = '1;

    les_pkg::floor_t floor_reg, floor_next;
    logic            stopped_reg, stopped_next;
    logic            dir_reg, dir_next;
    les_pkg::timer_t timer_reg, timer_next;
    les_pkg::map_t   map_reg, map_next;
    les_pkg::floor_t head_reg, head_next;
    logic            b_valid_reg;
    stage_t          b_reg, b_next;

    les_pkg::floor_t limit;
    logic            on_ok, to_ok;
    logic            accept, b_adv;
    logic            is_req;
    les_pkg::map_t   add_bits;
    les_pkg::map_t   map_serve;
    les_pkg::floor_t head_serve;
    logic            dir_serve;

    assign limit  = (cfg.top_floor < les_pkg::FLOOR_W'(les_pkg::MAX_FLOORS)) ?
                    cfg.top_floor : les_pkg::FLOOR_W'(les_pkg::MAX_FLOORS);
    assign on_ok  = (call_floor != '0) && (call_floor <= limit);
    assign to_ok  = (dest_floor != '0) && (dest_floor <= limit);

    assign b_adv    = b_valid_reg && res_ready;
    assign in_ready = !b_valid_reg || (res_ready && !b_reg.serve);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        floor_next   = floor_reg;
        stopped_next = stopped_reg;
        dir_next     = dir_reg;
        timer_next   = timer_reg;
        map_next     = map_reg;
        head_next    = head_reg;
        add_bits     = '0;
        is_req       = 1'b0;
        b_next       = '0;
        case (kind)
            les_pkg::KIND_HALL:
            begin
                if (on_ok && to_ok)
                begin
                    add_bits       = les_pkg::map_t'(1) << (call_floor - les_pkg::FLOOR_W'(1));
                    is_req         = 1'b1;
                    b_next.wr_hall = 1'b1;
                    b_next.addr    = les_pkg::ADDR_W'(call_floor - les_pkg::FLOOR_W'(1));
                    b_next.set_bits = les_pkg::map_t'(1) << (dest_floor - les_pkg::FLOOR_W'(1));
                end
                else
                begin
                    b_next.res.rejected = 1'b1;
                end
            end
            les_pkg::KIND_BUTTON:
            begin
                if (to_ok)
                begin
                    add_bits = les_pkg::map_t'(1) << (dest_floor - les_pkg::FLOOR_W'(1));
                    is_req   = 1'b1;
                end
                else
                begin
                    b_next.res.rejected = 1'b1;
                end
            end
            les_pkg::KIND_TICK:
            begin
                if (head_reg == '0)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    if (stopped_reg)
                    begin
                        timer_next   = '0;
                        stopped_next = 1'b0;
                        dir_next     = floor_reg < head_reg;
                    end
                    else if (timer_reg != TIMER_MAX)
                    begin
                        timer_next = timer_reg + les_pkg::TIMER_BITS'(1);
                    end
                    if (32'(timer_next) > 32'(cfg.floor_ticks))
                    begin
                        if (dir_next)
                        begin
                            if (floor_reg < les_pkg::FLOOR_W'(les_pkg::MAX_FLOORS))
                            begin
                                floor_next = floor_reg + les_pkg::FLOOR_W'(1);
                            end
                        end
                        else if (floor_reg > les_pkg::FLOOR_W'(1))
                        begin
                            floor_next = floor_reg - les_pkg::FLOOR_W'(1);
                        end
                        timer_next         = '0;
                        b_next.res.arrived = 1'b1;
                    end
                    if (floor_next == head_reg)
                    begin
                        b_next.serve      = 1'b1;
                        b_next.addr       = les_pkg::ADDR_W'(floor_next - les_pkg::FLOOR_W'(1));
                        b_next.res.served = 1'b1;
                    end
                end
            end
            default:
            begin
                is_req = 1'b0;
            end
        endcase
        if (is_req)
        begin
            map_next  = map_reg | add_bits;
            head_next = les_pkg::look_rank(map_reg | add_bits, floor_reg, dir_reg);
        end
        b_next.res.cabin_floor = floor_next;
        b_next.res.moving      = !stopped_next;
        b_next.res.going_up    = dir_next;
        b_next.res.next_floor  = head_next;
    end

    // Serve: merge the pending row into the targets and re-rank.
    assign map_serve  = (map_reg & ~(les_pkg::map_t'(1) << b_reg.addr)) | row;
    assign head_serve = les_pkg::look_rank(map_serve, floor_reg, dir_reg);
    assign dir_serve  = (head_serve != '0) ? !(floor_reg > head_serve) : dir_reg;

    always_comb
    begin
        res = b_reg.res;
        if (b_reg.serve)
        begin
            res.going_up   = dir_serve;
            res.next_floor = head_serve;
        end
    end

    assign res_valid = b_valid_reg;

    always_comb
    begin
        mem_req.rd_en   = accept;
        mem_req.rd_addr = b_next.addr;
        mem_req.wr_en   = b_adv && (b_reg.serve || b_reg.wr_hall);
        mem_req.wr_addr = b_reg.addr;
        mem_req.wr_data = b_reg.serve ? '0 : (row | b_reg.set_bits);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= les_pkg::FLOOR_W'(1);
            stopped_reg <= 1'b1;
            dir_reg     <= 1'b1;
            timer_reg   <= '0;
            map_reg     <= '0;
            head_reg    <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                floor_reg   <= floor_next;
                stopped_reg <= stopped_next;
                dir_reg     <= dir_next;
                timer_reg   <= timer_next;
                map_reg     <= map_next;
                head_reg    <= head_next;
                b_valid_reg <= 1'b1;
            end
            else
            begin
                if (b_adv)
                begin
                    b_valid_reg <= 1'b0;
                end
                if (b_adv && b_reg.serve)
                begin
                    map_reg  <= map_serve;
                    head_reg <= head_serve;
                    dir_reg  <= dir_serve;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg <= b_next;
        end
    end

endmodule

FILE: rtl/core/look_elevator_scheduler.sv
// LOOK elevator scheduler for one cabin: an item enters every cycle unless
// the output stalls, and its result passes the stage register in les_ctrl and
// leaves from an output register; a tick that serves a floor blocks input
// while the floor's pending row, read from the 32-entry row memory (one
// read port, one write port), merges into the target map before the next
// item ranks against it. The row memory is cleared at reset by per-row
// valid bits, so no clearing pass is needed. Configuration: top_floor at
// 0x0, floor_ticks at 0x4. Uses les_pkg, les_row_mem and les_ctrl.
module look_elevator_scheduler
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [les_pkg::KIND_W-1:0]    kind,
    input  les_pkg::floor_t               call_floor,
    input  les_pkg::floor_t               dest_floor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output les_pkg::floor_t               cabin_floor,
    output logic                          moving,
    output logic                          going_up,
    output les_pkg::floor_t               next_floor,
    output logic                          arrived,
    output logic                          served,
    output logic                          rejected
);

    localparam logic REG_TOP_FLOOR   = 1'b0;
    localparam logic REG_FLOOR_TICKS = 1'b1;

    les_pkg::cfg_t      cfg_reg;
    logic               out_valid_reg;
    les_pkg::res_t      out_reg;
    logic               res_valid;
    logic               res_ready;
    les_pkg::res_t      res;
    les_pkg::mem_req_t  mem_req;
    les_pkg::map_t      row;
    logic               wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_floor   <= les_pkg::FLOOR_W'(32);
            cfg_reg.floor_ticks <= les_pkg::TICKS_W'(3);
        end
        else if (wr_stb)
        begin
            case (paddr[2])
                REG_TOP_FLOOR:   cfg_reg.top_floor   <= pwdata[les_pkg::FLOOR_W-1:0];
                REG_FLOOR_TICKS: cfg_reg.floor_ticks <= pwdata[les_pkg::TICKS_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TOP_FLOOR:   prdata = 32'(cfg_reg.top_floor);
            REG_FLOOR_TICKS: prdata = 32'(cfg_reg.floor_ticks);
            default:         prdata = '0;
        endcase
    end

    les_row_mem u_row_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .row     (row)
    );

    les_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .call_floor (call_floor),
        .dest_floor (dest_floor),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .row        (row)
    );

    // Hold the result until the transaction completes.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cabin_floor = out_reg.cabin_floor;
    assign moving      = out_reg.moving;
    assign going_up    = out_reg.going_up;
    assign next_floor  = out_reg.next_floor;
    assign arrived     = out_reg.arrived;
    assign served      = out_reg.served;
    assign rejected    = out_reg.rejected;

endmodule

FILE: rtl/core/les_checker.sv
// Port-level checks for look_elevator_scheduler, attached by bind.
// Uses les_pkg.
module les_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input les_pkg::floor_t cabin_floor,
    input logic            moving,
    input les_pkg::floor_t next_floor,
    input logic            arrived,
    input logic            served,
    input logic            rejected
);

    a_move_implies_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (arrived || served) |-> moving)
        else $error("arrival or service reported while stopped");

    a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> !arrived && !served)
        else $error("rejected request reported a cabin step");

    a_floor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cabin_floor != '0)
                      && (cabin_floor <= les_pkg::FLOOR_W'(les_pkg::MAX_FLOORS))
                      && (next_floor <= les_pkg::FLOOR_W'(les_pkg::MAX_FLOORS)))
        else $error("floor out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cabin_floor) && $stable(next_floor))
        else $error("stalled result changed");

endmodule

bind look_elevator_scheduler les_checker u_les_checker (.*);

FILE: tb/sv/look_sched_checker.sv
// Scoreboard for the LOOK elevator scheduler: snoops the APB writes and both
// transaction channels, predicts each result and compares it with the one observed.
// Depends on les_pkg.
`timescale 1ns / 1ps

module look_sched_checker
#(
    parameter logic [2:0] TOP_FLOOR_ADDR   = 3'h0,
    parameter logic [2:0] FLOOR_TICKS_ADDR = 3'h4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [les_pkg::KIND_W-1:0] kind,
    input  les_pkg::floor_t            call_floor,
    input  les_pkg::floor_t            dest_floor,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  les_pkg::floor_t            cabin_floor,
    input  logic                       moving,
    input  logic                       going_up,
    input  les_pkg::floor_t            next_floor,
    input  logic                       arrived,
    input  logic                       served,
    input  logic                       rejected,
    output int                         fail_count,
    output int                         waiting,
    output int                         results_checked,
    output int                         floors_served
);

    les_pkg::floor_t    top_floor_cfg;
    logic [15:0]        floor_ticks_cfg;

    les_pkg::floor_t    cabin_at;
    logic               parked;
    logic               heading_up;
    les_pkg::timer_t    travel_timer;
    les_pkg::map_t      call_map;
    les_pkg::map_t      drop_rows [les_pkg::MAX_FLOORS];
    les_pkg::floor_t    next_stop;

    les_pkg::res_t      expected_stops [$];
    les_pkg::res_t      got;
    les_pkg::res_t      want;
    les_pkg::res_t      predicted;

    function automatic les_pkg::map_t floor_mask(les_pkg::floor_t f);
        return les_pkg::map_t'(1) << (f - les_pkg::floor_t'(1));
    endfunction

    function automatic bit floor_in_range(les_pkg::floor_t f);
        les_pkg::floor_t lim;
        lim = (top_floor_cfg < les_pkg::MAX_FLOORS) ? top_floor_cfg
                                                    : les_pkg::floor_t'(les_pkg::MAX_FLOORS);
        return (f >= 1) && (f <= lim);
    endfunction

    // Rank by LOOK: nearest ahead, then here, then nearest behind.
    function automatic void pick_next_stop();
        les_pkg::floor_t above;
        les_pkg::floor_t below;
        bit              here;
        above = '0;
        below = '0;
        here  = 1'b0;
        for (int f = 1; f <= les_pkg::MAX_FLOORS; f++)
        begin
            if (call_map[f-1])
            begin
                if (f > cabin_at)
                begin
                    if (above == '0)
                    begin
                        above = les_pkg::floor_t'(f);
                    end
                end
                else if (f < cabin_at)
                begin
                    below = les_pkg::floor_t'(f);
                end
                else
                begin
                    here = 1'b1;
                end
            end
        end
        if (heading_up)
        begin
            next_stop = (above != '0) ? above : (here ? cabin_at : below);
        end
        else
        begin
            next_stop = (below != '0) ? below : (here ? cabin_at : above);
        end
    endfunction

    function automatic les_pkg::res_t take_item(logic [les_pkg::KIND_W-1:0] k,
                                                les_pkg::floor_t on_f,
                                                les_pkg::floor_t to_f);
        les_pkg::res_t r;
        les_pkg::map_t row;
        r = '0;
        case (k)
            les_pkg::KIND_HALL:
            begin
                if (floor_in_range(on_f) && floor_in_range(to_f))
                begin
                    call_map = call_map | floor_mask(on_f);
                    drop_rows[on_f - 1] = drop_rows[on_f - 1] | floor_mask(to_f);
                    pick_next_stop();
                end
                else
                begin
                    r.rejected = 1'b1;
                end
            end
            les_pkg::KIND_BUTTON:
            begin
                if (floor_in_range(to_f))
                begin
                    call_map = call_map | floor_mask(to_f);
                    pick_next_stop();
                end
                else
                begin
                    r.rejected = 1'b1;
                end
            end
            les_pkg::KIND_TICK:
            begin
                if (next_stop == '0)
                begin
                    parked = 1'b1;
                end
                else
                begin
                    if (parked)
                    begin
                        travel_timer = '0;
                        parked       = 1'b0;
                        heading_up   = cabin_at < next_stop;
                    end
                    else if (travel_timer != '1)
                    begin
                        travel_timer = travel_timer + 1'b1;
                    end
                    if (travel_timer > floor_ticks_cfg)
                    begin
                        if (heading_up)
                        begin
                            if (cabin_at < les_pkg::MAX_FLOORS)
                            begin
                                cabin_at = cabin_at + 1'b1;
                            end
                        end
                        else if (cabin_at > 1)
                        begin
                            cabin_at = cabin_at - 1'b1;
                        end
                        travel_timer = '0;
                        r.arrived    = 1'b1;
                    end
                    if (cabin_at == next_stop)
                    begin
                        row = drop_rows[cabin_at - 1];
                        drop_rows[cabin_at - 1] = '0;
                        call_map = (call_map & ~floor_mask(cabin_at)) | row;
                        pick_next_stop();
                        if (next_stop != '0)
                        begin
                            heading_up = !(cabin_at > next_stop);
                        end
                        r.served = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.cabin_floor = cabin_at;
        r.moving      = !parked;
        r.going_up    = heading_up;
        r.next_floor  = next_stop;
        return r;
    endfunction

    function automatic string describe_result(les_pkg::res_t r);
        return $sformatf("floor %0d moving %b up %b next %0d arrived %b served %b rejected %b",
                         r.cabin_floor, r.moving, r.going_up, r.next_floor,
                         r.arrived, r.served, r.rejected);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_floor_cfg   = les_pkg::floor_t'(32);
            floor_ticks_cfg = 16'd3;
            cabin_at        = les_pkg::floor_t'(1);
            parked          = 1'b1;
            heading_up      = 1'b1;
            travel_timer    = '0;
            call_map        = '0;
            next_stop       = '0;
            for (int i = 0; i < les_pkg::MAX_FLOORS; i++)
            begin
                drop_rows[i] = '0;
            end
            expected_stops.delete();
            fail_count      = 0;
            results_checked = 0;
            floors_served   = 0;
            waiting         = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == TOP_FLOOR_ADDR)
                begin
                    top_floor_cfg = pwdata[les_pkg::FLOOR_W-1:0];
                end
                else if (paddr == FLOOR_TICKS_ADDR)
                begin
                    floor_ticks_cfg = pwdata[les_pkg::TICKS_W-1:0];
                end
            end
            if (out_valid && out_ready)
            begin
                got.cabin_floor = cabin_floor;
                got.moving      = moving;
                got.going_up    = going_up;
                got.next_floor  = next_floor;
                got.arrived     = arrived;
                got.served      = served;
                got.rejected    = rejected;
                if (expected_stops.size() == 0)
                begin
                    $display("%0t: unexpected result: %s", $time, describe_result(got));
                    fail_count++;
                end
                else
                begin
                    want = expected_stops.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result %0d mismatch", $time, results_checked);
                        $display("    expected %s", describe_result(want));
                        $display("    actual   %s", describe_result(got));
                        fail_count++;
                    end
                    if (want.served)
                    begin
                        floors_served++;
                    end
                    results_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                predicted = take_item(kind, call_floor, dest_floor);
                expected_stops.insert(expected_stops.size(), predicted);
            end
            waiting = expected_stops.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the LOOK elevator scheduler testbench: clock, reset, APB setup,
// request stimulus with random idling, watchdog and verdict.
// Depends on les_pkg, look_elevator_scheduler and look_sched_checker.
`timescale 1ns / 1ps

module testbench;

    localparam logic [2:0] REG_TOP_FLOOR   = 3'h0;
    localparam logic [2:0] REG_FLOOR_TICKS = 3'h4;
    localparam int         IDLE_LIMIT      = 1000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         SETTLE_CYCLES   = 4;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic [les_pkg::KIND_W-1:0] kind;
    les_pkg::floor_t            call_floor;
    les_pkg::floor_t            dest_floor;
    logic                       out_valid;
    logic                       out_ready;
    les_pkg::floor_t            cabin_floor;
    logic                       moving;
    logic                       going_up;
    les_pkg::floor_t            next_floor;
    logic                       arrived;
    logic                       served;
    logic                       rejected;

    int                         fail_count;
    int                         waiting;
    int                         results_checked;
    int                         floors_served;

    int                         sender_idle_pct;
    int                         receiver_idle_pct;
    int                         stall_cycles;
    int                         requests_sent;
    int                         settings_used;
    les_pkg::floor_t            top_in_use;

    look_elevator_scheduler dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .call_floor  (call_floor),
        .dest_floor  (dest_floor),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cabin_floor (cabin_floor),
        .moving      (moving),
        .going_up    (going_up),
        .next_floor  (next_floor),
        .arrived     (arrived),
        .served      (served),
        .rejected    (rejected)
    );

    look_sched_checker
    #(
        .TOP_FLOOR_ADDR   (REG_TOP_FLOOR),
        .FLOOR_TICKS_ADDR (REG_FLOOR_TICKS)
    )
    look_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .call_floor      (call_floor),
        .dest_floor      (dest_floor),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cabin_floor     (cabin_floor),
        .moving          (moving),
        .going_up        (going_up),
        .next_floor      (next_floor),
        .arrived         (arrived),
        .served          (served),
        .rejected        (rejected),
        .fail_count      (fail_count),
        .waiting         (waiting),
        .results_checked (results_checked),
        .floors_served   (floors_served)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hold the transaction until accepted; leave valid high for the next one.
    task automatic push_request(input logic [les_pkg::KIND_W-1:0] k,
                                input les_pkg::floor_t a, input les_pkg::floor_t b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        kind       = k;
        call_floor = a;
        dest_floor = b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input les_pkg::floor_t top, input logic [15:0] ticks);
        settle();
        write_register(REG_TOP_FLOOR, 32'(top));
        write_register(REG_FLOOR_TICKS, 32'(ticks));
        top_in_use = top;
        settings_used++;
    endtask

    task automatic random_traffic(input int count);
        int              tick_run;
        int              pick;
        les_pkg::floor_t a;
        les_pkg::floor_t b;
        tick_run = 0;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            a    = les_pkg::floor_t'($urandom_range(1, top_in_use));
            b    = les_pkg::floor_t'($urandom_range(1, top_in_use));
            if (tick_run > 0)
            begin
                tick_run--;
                push_request(les_pkg::KIND_TICK, les_pkg::floor_t'($urandom_range(63)),
                             les_pkg::floor_t'($urandom_range(63)));
            end
            else if (pick < 6)
            begin
                tick_run = $urandom_range(10, 40);
                push_request(les_pkg::KIND_TICK, les_pkg::floor_t'($urandom_range(63)),
                             les_pkg::floor_t'($urandom_range(63)));
            end
            else if (pick < 50)
            begin
                push_request(les_pkg::KIND_TICK, les_pkg::floor_t'($urandom_range(63)),
                             les_pkg::floor_t'($urandom_range(63)));
            end
            else if (pick < 70)
            begin
                push_request(les_pkg::KIND_HALL, a, b);
            end
            else if (pick < 86)
            begin
                push_request(les_pkg::KIND_BUTTON, les_pkg::floor_t'($urandom_range(63)), b);
            end
            else if (pick < 91)
            begin
                push_request($urandom_range(1) ? les_pkg::KIND_HALL : les_pkg::KIND_BUTTON,
                             $urandom_range(1) ? top_in_use + 1'b1 : a,
                             $urandom_range(1) ? top_in_use + 1'b1 : '0);
            end
            else
            begin
                push_request(les_pkg::KIND_W'($urandom_range(3)),
                             les_pkg::floor_t'($urandom_range(63)),
                             les_pkg::floor_t'($urandom_range(63)));
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_valid          = 1'b0;
        kind              = les_pkg::KIND_TICK;
        call_floor        = '0;
        dest_floor        = '0;
        out_ready         = 1'b0;
        stall_cycles      = 0;
        requests_sent     = 0;
        settings_used     = 1;
        top_in_use        = les_pkg::floor_t'(32);
        sender_idle_pct   = 30;
        receiver_idle_pct = 65;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_request(les_pkg::KIND_TICK, 6'd63, 6'd63);
        push_request(les_pkg::KIND_SPARE, 6'd5, 6'd7);
        push_request(les_pkg::KIND_HALL, 6'd0, 6'd5);
        push_request(les_pkg::KIND_HALL, 6'd5, 6'd33);
        push_request(les_pkg::KIND_HALL, 6'd63, 6'd1);
        push_request(les_pkg::KIND_BUTTON, 6'd1, 6'd0);
        push_request(les_pkg::KIND_BUTTON, 6'd0, 6'd33);
        push_request(les_pkg::KIND_BUTTON, 6'd63, 6'd32);
        push_request(les_pkg::KIND_HALL, 6'd1, 6'd3);
        push_request(les_pkg::KIND_HALL, 6'd4, 6'd1);
        repeat (10) push_request(les_pkg::KIND_TICK, 6'd0, 6'd0);
        push_request(les_pkg::KIND_BUTTON, 6'd0, 6'd1);
        repeat (4) push_request(les_pkg::KIND_TICK, 6'd32, 6'd32);

        random_traffic(275);
        apply_setting(6'd2, 16'd0);
        random_traffic(275);

        sender_idle_pct   = 65;
        receiver_idle_pct = 30;
        apply_setting(6'd32, 16'd65535);
        random_traffic(100);
        apply_setting(les_pkg::floor_t'($urandom_range(3, 31)), 16'($urandom_range(0, 4)));
        random_traffic(275);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        apply_setting(6'd32, 16'd0);
        random_traffic(275);
        apply_setting(les_pkg::floor_t'($urandom_range(2, 32)), 16'($urandom_range(1, 6)));
        random_traffic(275);

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d requests and ticks under %0d register settings;", requests_sent,
                 settings_used);
        $display("checked %0d results, %0d of them serving a floor.", results_checked,
                 floors_served);
        if (fail_count == 0 && waiting == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
